// ===== hdl/rrfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rrfp_pkg
// Shared types and constants of the radar report frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rrfp_pkg;

  // Frame delimiters
  localparam logic [7:0] HDR_BYTE [0:3] = '{8'hF4, 8'hF3, 8'hF2, 8'hF1};
  localparam logic [7:0] TRL_BYTE [0:3] = '{8'hF8, 8'hF7, 8'hF6, 8'hF5};

  // Report payload markers
  localparam logic [7:0]  RPT_TYPE     = 8'h02;
  localparam logic [7:0]  RPT_HEAD     = 8'hAA;
  localparam logic [15:0] MIN_RPT_LEN  = 16'd13;
  localparam int          CAP_BYTES    = 9;
  localparam int          CAP_IDX_W    = $clog2(CAP_BYTES);
  localparam logic [7:0]  DEADBAND_RST = 8'd3;

  // Queue between the parser front and the report back end
  localparam int Q_DEPTH = 2;
  localparam int Q_IDX_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Direction codes (two's complement)
  localparam logic [1:0] DIR_STEADY = 2'b00;
  localparam logic [1:0] DIR_FARTHER = 2'b01;
  localparam logic [1:0] DIR_NEARER = 2'b11;

  // Parser phase
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_TRAILER = 3'd4
  } phase_t;

  // Classified report handed from front to back
  typedef struct packed {
    logic        st_nz;
    logic [15:0] sel_cm;
    logic [7:0]  energy;
  } rpt_rec_t;

endpackage

`default_nettype wire

// ===== hdl/rrfp_byte_if.sv =====
// ----------------------------------------------------------------------------
// rrfp_byte_if
// Valid/ready channel carrying one received serial byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/rrfp_rpt_if.sv =====
// ----------------------------------------------------------------------------
// rrfp_rpt_if
// Valid/ready channel carrying one presence report per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrfp_rpt_if;
  logic              valid;
  logic              ready;
  logic              present;
  logic signed [15:0] range_cm;
  logic [7:0]        energy;
  logic              n_targets;
  logic signed [1:0] direction;

  modport source (output valid, output present, output range_cm, output energy,
                  output n_targets, output direction, input ready);
  modport sink   (input valid, input present, input range_cm, input energy,
                  input n_targets, input direction, output ready);
endinterface

`default_nettype wire

// ===== hdl/rrfp_front.sv =====
// ----------------------------------------------------------------------------
// rrfp_front
// Byte parser: header hunt, length, payload capture, trailer check; pushes
// one classified record per valid report frame.
// ----------------------------------------------------------------------------
`default_nettype none

module rrfp_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,      // byte accepted this cycle
  input  wire logic [7:0]         rx_byte,
  output      logic               push,
  output      rrfp_pkg::rpt_rec_t push_rec
);

  rrfp_pkg::phase_t phase, phase_next;
  logic [1:0]  match, match_next;
  logic [15:0] len, len_next;
  logic [15:0] pos, pos_next;
  logic [7:0]  cap [rrfp_pkg::CAP_BYTES];
  logic [15:0] pos_inc;
  logic        trl_hit;
  logic        frame_ok;

  assign pos_inc = pos + 16'd1;
  assign trl_hit = (rx_byte == rrfp_pkg::TRL_BYTE[match]);

  // Next state
  always_comb begin
    phase_next = phase;
    match_next = match;
    len_next   = len;
    pos_next   = pos;
    if (take) begin
      case (phase)
        rrfp_pkg::PH_LEN_LO: begin
          len_next   = {8'd0, rx_byte};
          phase_next = rrfp_pkg::PH_LEN_HI;
        end
        rrfp_pkg::PH_LEN_HI: begin
          len_next   = {rx_byte, len[7:0]};
          pos_next   = 16'd0;
          match_next = 2'd0;
          phase_next = ({rx_byte, len[7:0]} == 16'd0) ? rrfp_pkg::PH_TRAILER
                                                       : rrfp_pkg::PH_PAYLOAD;
        end
        rrfp_pkg::PH_PAYLOAD: begin
          pos_next = pos_inc;
          if (pos_inc == len) begin
            match_next = 2'd0;
            phase_next = rrfp_pkg::PH_TRAILER;
          end
        end
        rrfp_pkg::PH_TRAILER: begin
          if (trl_hit && match != 2'd3) begin
            match_next = match + 2'd1;
          end else begin
            match_next = 2'd0;
            phase_next = rrfp_pkg::PH_HUNT;
          end
        end
        default: begin
          // hunting; unused codes fall here too
          phase_next = rrfp_pkg::PH_HUNT;
          if (rx_byte == rrfp_pkg::HDR_BYTE[match]) begin
            if (match == 2'd3) begin
              match_next = 2'd0;
              phase_next = rrfp_pkg::PH_LEN_LO;
            end else begin
              match_next = match + 2'd1;
            end
          end else begin
            match_next = (rx_byte == rrfp_pkg::HDR_BYTE[0]) ? 2'd1 : 2'd0;
          end
        end
      endcase
    end
  end

  // Outputs: frame complete and payload is a report
  always_comb begin
    frame_ok = (len >= rrfp_pkg::MIN_RPT_LEN) && (cap[0] == rrfp_pkg::RPT_TYPE) &&
               (cap[1] == rrfp_pkg::RPT_HEAD);
    push = take && (phase == rrfp_pkg::PH_TRAILER) && trl_hit && (match == 2'd3) &&
           frame_ok;
    push_rec.st_nz = (cap[2] != 8'd0);
    if (cap[2][0]) begin
      push_rec.sel_cm = {cap[4], cap[3]};
      push_rec.energy = cap[5];
    end else if (cap[2][1]) begin
      push_rec.sel_cm = {cap[7], cap[6]};
      push_rec.energy = cap[8];
    end else begin
      push_rec.sel_cm = 16'd0;
      push_rec.energy = 8'd0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= rrfp_pkg::PH_HUNT;
      match <= 2'd0;
      len   <= 16'd0;
      pos   <= 16'd0;
    end else begin
      phase <= phase_next;
      match <= match_next;
      len   <= len_next;
      pos   <= pos_next;
    end
  end

  // Payload capture of the leading bytes
  always_ff @(posedge clk) begin
    if (take && phase == rrfp_pkg::PH_PAYLOAD &&
        pos < 16'(rrfp_pkg::CAP_BYTES)) begin
      cap[pos[rrfp_pkg::CAP_IDX_W-1:0]] <= rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rrfp_queue.sv =====
// ----------------------------------------------------------------------------
// rrfp_queue
// Short FIFO of classified records between parser front and report back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rrfp_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire rrfp_pkg::rpt_rec_t push_rec,
  output      logic               full,
  input  wire logic               pop,
  output      rrfp_pkg::rpt_rec_t pop_rec,
  output      logic               empty
);

  rrfp_pkg::rpt_rec_t mem [rrfp_pkg::Q_DEPTH];
  logic [rrfp_pkg::Q_IDX_W-1:0] wr_ptr;
  logic [rrfp_pkg::Q_IDX_W-1:0] rd_ptr;
  logic [rrfp_pkg::Q_CNT_W-1:0] count;

  assign full    = (count == rrfp_pkg::Q_CNT_W'(rrfp_pkg::Q_DEPTH));
  assign empty   = (count == '0);
  assign pop_rec = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == rrfp_pkg::Q_IDX_W'(rrfp_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == rrfp_pkg::Q_IDX_W'(rrfp_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    count <= rrfp_pkg::Q_CNT_W'(rrfp_pkg::Q_DEPTH))
    else $error("queue count beyond depth");
  a_cnt_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");
  a_cnt_dn: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1)
    else $error("queue count did not shrink on pop");
  a_no_ovf: assert property (@(posedge clk) disable iff (rst)
    full && !pop |-> !push)
    else $error("push into full queue");

endmodule

`default_nettype wire

// ===== hdl/rrfp_back.sv =====
// ----------------------------------------------------------------------------
// rrfp_back
// Report stage: presence, direction against the last distance, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rrfp_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [7:0]         cfg_wdata,
  input  wire logic               q_empty,
  input  wire rrfp_pkg::rpt_rec_t q_rec,
  output      logic               q_pop,
  rrfp_rpt_if.source              rpt
);

  logic [7:0]         deadband;
  logic [15:0]        last_dist;
  logic               out_valid;
  logic [15:0]        delta;
  logic signed [16:0] delta_s;
  logic signed [16:0] db_pos;
  logic signed [16:0] db_neg;
  logic [1:0]         dir;
  logic               pres;

  // Pop when the output register is free or being emptied
  assign q_pop = !q_empty && (!out_valid || rpt.ready);

  // Presence and direction
  always_comb begin
    delta   = q_rec.sel_cm - last_dist;
    delta_s = {delta[15], delta};
    db_pos  = {9'd0, deadband};
    db_neg  = -db_pos;
    pres    = q_rec.st_nz && !q_rec.sel_cm[15] && (q_rec.sel_cm != 16'd0);
    if (delta_s < db_neg) begin
      dir = rrfp_pkg::DIR_NEARER;
    end else if (delta_s > db_pos) begin
      dir = rrfp_pkg::DIR_FARTHER;
    end else begin
      dir = rrfp_pkg::DIR_STEADY;
    end
  end

  // Control: dead band, last distance, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      deadband  <= rrfp_pkg::DEADBAND_RST;
      last_dist <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        deadband <= cfg_wdata;
      end
      if (q_pop) begin
        last_dist <= q_rec.sel_cm;
        out_valid <= 1'b1;
      end else if (rpt.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rpt.present   <= pres;
      rpt.range_cm  <= q_rec.sel_cm;
      rpt.energy    <= q_rec.energy;
      rpt.n_targets <= pres;
      rpt.direction <= dir;
    end
  end

  assign rpt.valid = out_valid;

  // Checks
  a_last_hold: assert property (@(posedge clk) disable iff (rst)
    !q_pop |=> $stable(last_dist))
    else $error("last distance changed without a report");
  a_last_track: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> last_dist == rpt.range_cm)
    else $error("shown report does not match last distance");
  a_count_pres: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rpt.n_targets == rpt.present)
    else $error("target count differs from presence");

endmodule

`default_nettype wire

// ===== hdl/radar_report_frame_parser_top.sv =====
// A report enters the record queue as its last trailer byte is taken, then the output
// register once free. Throughput: one byte per cycle while the queue is not full; the
// front steps per byte taken; a 2-entry queue and the output register absorb stalls.
// Input ready drops only while the record queue is full.
// Reset (rst, synchronous): parser hunts for a header, last distance 0, dead band 3.
// ----------------------------------------------------------------------------
// radar_report_frame_parser_top
// Presence-radar report frame parser: byte stream in, presence reports out.
// ----------------------------------------------------------------------------
`default_nettype none

module radar_report_frame_parser_top (
  input  wire logic  clk,
  input  wire logic  rst,
  rrfp_byte_if.sink  rx,
  rrfp_rpt_if.source rpt,
  input  wire logic  cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  logic               take;
  logic               push;
  rrfp_pkg::rpt_rec_t push_rec;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  rrfp_pkg::rpt_rec_t q_rec;

  // Byte acceptance
  assign rx.ready = !q_full;
  assign take     = rx.valid && !q_full;

  rrfp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .rx_byte  (rx.rx_byte),
    .push     (push),
    .push_rec (push_rec)
  );

  rrfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (q_pop),
    .pop_rec  (q_rec),
    .empty    (q_empty)
  );

  rrfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .q_rec     (q_rec),
    .q_pop     (q_pop),
    .rpt       (rpt)
  );

endmodule

`default_nettype wire
